FILE: hw/rtl/sorted_priority_queue_top_assert.svh
// Assertion macros for the sorted priority queue RTL.
// Used inside modules that have clk and arst_n in scope; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define SPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SPQ_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`else
`define SPQ_ASSERT(label, prop, msg)
`define SPQ_ASSERT_IMPLY(label, pre, post, msg)
`endif

`endif

FILE: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies.
`default_nettype none

package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_WIDTH = 16;
	localparam int ELEM_W    = 16;
	localparam int PRIO_W    = 16;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int IDX_W     = $clog2(DEPTH);

	localparam logic [CNT_W-1:0] ITER_END = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		REQ_INSERT   = 3'd0,
		REQ_POP      = 3'd1,
		REQ_REMOVE   = 3'd2,
		REQ_CHANGE   = 3'd3,
		REQ_CONTAINS = 3'd4,
		REQ_FIRST    = 3'd5,
		REQ_NEXT     = 3'd6,
		REQ_CLEAR    = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NOTFOUND = 2'd1,
		STS_FULL     = 2'd2,
		STS_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REINS
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_mode_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0] elem;
		logic [PRIO_W-1:0]    prio;
	} entry_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		cell_mode_t           mode;
		logic [KEY_WIDTH-1:0] key;
		logic [PRIO_W-1:0]    prio;
		logic                 match_prio;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_priority_queue_top.sv
// Sorted priority queue top level: request controller and the row of cells.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_top_assert.svh.
`default_nettype none
`include "sorted_priority_queue_top_assert.svh"

// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall it, so it must sample on that cycle. Most requests need the accepting edge
// and one execute cycle in which the whole cell row compares and shifts; the result
// appears in the next cycle, when a new request may already be accepted. Change
// priority also goes through the reinsert state, as the row makes a removal pass
// and then an insertion pass. Entries sit sorted by descending priority, older
// first among equals; only the state, entry count, iterator and done strobe reset.
module sorted_priority_queue_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [15:0] element,
	input  wire logic [15:0] priority_req,
	input  wire logic [15:0] target_priority,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      out_element,
	output logic [15:0]      out_priority,
	output logic             found,
	output logic [4:0]       size
);

	localparam int DEPTH = spq_pkg::DEPTH;
	localparam int CNT_W = spq_pkg::CNT_W;
	localparam int IDX_W = spq_pkg::IDX_W;

	spq_pkg::state_t  state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] iter_q, iter_d;

	spq_pkg::req_t                  req_q;
	logic [spq_pkg::KEY_WIDTH-1:0]  key_q;
	logic [spq_pkg::PRIO_W-1:0]     prio_q;
	logic [spq_pkg::PRIO_W-1:0]     nprio_q;

	logic                           done_q, done_d;
	spq_pkg::status_t               status_q, status_d;
	logic [15:0]                    oe_q, oe_d;
	logic [15:0]                    op_q, op_d;
	logic                           found_q, found_d;
	logic [4:0]                     size_q;

	spq_pkg::cell_ctl_t ctl;
	spq_pkg::entry_t    new_entry;
	logic               pop_sel;
	spq_pkg::entry_t    cell_q   [DEPTH];
	logic               ins_w    [DEPTH];
	logic               hit_w    [DEPTH];
	logic               any_hit;

	logic [CNT_W:0]     iter_inc;
	logic [IDX_W-1:0]   rd_idx;
	spq_pkg::entry_t    rd_entry;

	logic accept;

	assign busy   = (state_q != spq_pkg::ST_IDLE);
	assign accept = start && !busy;

	// Cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::entry_t left_w, right_w;
		logic            ins_prev_w, hit_prev_w;

		if (i == 0) begin : g_head
			assign left_w     = '0;
			assign ins_prev_w = 1'b0;
			assign hit_prev_w = pop_sel;
		end else begin : g_mid
			assign left_w     = cell_q[i-1];
			assign ins_prev_w = ins_w[i-1];
			assign hit_prev_w = hit_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_body
			assign right_w = cell_q[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.valid     (CNT_W'(i) < count_q),
			.new_entry (new_entry),
			.left      (left_w),
			.right     (right_w),
			.ins_prev  (ins_prev_w),
			.hit_prev  (hit_prev_w),
			.ins       (ins_w[i]),
			.hit       (hit_w[i]),
			.q         (cell_q[i])
		);
	end

	assign any_hit  = hit_w[DEPTH-1];
	assign iter_inc = {1'b0, iter_q} + (CNT_W+1)'(1);
	assign rd_idx   = iter_inc[IDX_W-1:0];
	assign rd_entry = cell_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
			count_q <= '0;
			iter_q  <= spq_pkg::ITER_END;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			iter_q  <= iter_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= spq_pkg::req_t'(req_type);
			key_q   <= spq_pkg::KEY_WIDTH'(element);
			prio_q  <= priority_req;
			nprio_q <= target_priority;
		end
		if (done_d) begin
			status_q <= status_d;
			oe_q     <= oe_d;
			op_q     <= op_d;
			found_q  <= found_d;
			size_q   <= 5'(count_d);
		end
	end

	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		iter_d         = iter_q;
		done_d         = 1'b0;
		status_d       = spq_pkg::STS_OK;
		oe_d           = '0;
		op_d           = '0;
		found_d        = 1'b0;
		ctl.mode       = spq_pkg::CELL_HOLD;
		ctl.key        = key_q;
		ctl.prio       = prio_q;
		ctl.match_prio = (req_q == spq_pkg::REQ_CHANGE);
		pop_sel        = (req_q == spq_pkg::REQ_POP);
		new_entry.elem = key_q;
		new_entry.prio = prio_q;

		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (start) begin
					state_d = spq_pkg::ST_EXEC;
				end
			end
			spq_pkg::ST_EXEC: begin
				state_d = spq_pkg::ST_IDLE;
				done_d  = 1'b1;
				unique case (req_q)
					spq_pkg::REQ_INSERT: begin
						if (count_q == CNT_W'(DEPTH)) begin
							status_d = spq_pkg::STS_FULL;
						end else begin
							ctl.mode = spq_pkg::CELL_INSERT;
							count_d  = count_q + CNT_W'(1);
							iter_d   = spq_pkg::ITER_END;
						end
					end
					spq_pkg::REQ_POP: begin
						if (count_q == '0) begin
							status_d = spq_pkg::STS_EMPTY;
						end else begin
							ctl.mode = spq_pkg::CELL_REMOVE;
							oe_d     = 16'(cell_q[0].elem);
							op_d     = cell_q[0].prio;
							count_d  = count_q - CNT_W'(1);
							iter_d   = spq_pkg::ITER_END;
						end
					end
					spq_pkg::REQ_REMOVE: begin
						if (any_hit) begin
							ctl.mode = spq_pkg::CELL_REMOVE;
							count_d  = count_q - CNT_W'(1);
							iter_d   = spq_pkg::ITER_END;
						end else begin
							status_d = spq_pkg::STS_NOTFOUND;
						end
					end
					spq_pkg::REQ_CHANGE: begin
						if (any_hit) begin
							// removal pass now, reinsertion next cycle
							ctl.mode = spq_pkg::CELL_REMOVE;
							count_d  = count_q - CNT_W'(1);
							state_d  = spq_pkg::ST_REINS;
							done_d   = 1'b0;
						end else begin
							status_d = spq_pkg::STS_NOTFOUND;
						end
					end
					spq_pkg::REQ_CONTAINS: begin
						found_d = any_hit;
					end
					spq_pkg::REQ_FIRST: begin
						if (count_q == '0) begin
							status_d = spq_pkg::STS_EMPTY;
							iter_d   = spq_pkg::ITER_END;
						end else begin
							iter_d = '0;
							oe_d   = 16'(cell_q[0].elem);
							op_d   = cell_q[0].prio;
						end
					end
					spq_pkg::REQ_NEXT: begin
						if (iter_q >= count_q || iter_inc >= {1'b0, count_q}) begin
							status_d = spq_pkg::STS_EMPTY;
							iter_d   = spq_pkg::ITER_END;
						end else begin
							iter_d = iter_inc[CNT_W-1:0];
							oe_d   = 16'(rd_entry.elem);
							op_d   = rd_entry.prio;
						end
					end
					spq_pkg::REQ_CLEAR: begin
						count_d = '0;
						iter_d  = spq_pkg::ITER_END;
					end
				endcase
			end
			spq_pkg::ST_REINS: begin
				ctl.mode       = spq_pkg::CELL_INSERT;
				ctl.prio       = nprio_q;
				new_entry.prio = nprio_q;
				count_d        = count_q + CNT_W'(1);
				iter_d         = spq_pkg::ITER_END;
				done_d         = 1'b1;
				state_d        = spq_pkg::ST_IDLE;
			end
			default: begin
				state_d = spq_pkg::ST_IDLE;
			end
		endcase
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_element  = oe_q;
	assign out_priority = op_q;
	assign found        = found_q;
	assign size         = size_q;

	`SPQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`SPQ_ASSERT_IMPLY(a_done_after_work, done, $past(state_q) != spq_pkg::ST_IDLE,
		"result strobe without a transaction in flight")
	`SPQ_ASSERT_IMPLY(a_reins_after_exec, state_q == spq_pkg::ST_REINS,
		$past(state_q) == spq_pkg::ST_EXEC, "reinsert pass without removal pass")
	`SPQ_ASSERT_IMPLY(a_full_size, done && status == spq_pkg::STS_FULL,
		size == 5'(DEPTH), "full status while store has room")
	`SPQ_ASSERT_IMPLY(a_accept_busy, $past(accept), busy,
		"accepted transaction did not raise busy")

endmodule

`default_nettype wire

FILE: hw/rtl/spq_cell.sv
// One slot of the sorted cell row: holds an entry, shifts right on insert,
// shifts left on removal. Depends on spq_pkg.
`default_nettype none

module spq_cell (
	input  wire logic               clk,
	input  wire spq_pkg::cell_ctl_t ctl,
	input  wire logic               valid,
	input  wire spq_pkg::entry_t    new_entry,
	input  wire spq_pkg::entry_t    left,
	input  wire spq_pkg::entry_t    right,
	input  wire logic               ins_prev,
	input  wire logic               hit_prev,
	output logic                    ins,
	output logic                    hit,
	output spq_pkg::entry_t         q
);

	spq_pkg::entry_t entry_q;
	logic            match;

	// ins is monotone along the row: false over the kept front, true from the slot on
	assign ins   = !valid || (ctl.prio > entry_q.prio);
	assign match = valid && (entry_q.elem == ctl.key) &&
		(!ctl.match_prio || (entry_q.prio == ctl.prio));
	assign hit   = hit_prev || match;
	assign q     = entry_q;

	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			spq_pkg::CELL_INSERT: begin
				if (ins) begin
					entry_q <= ins_prev ? left : new_entry;
				end
			end
			spq_pkg::CELL_REMOVE: begin
				if (hit) begin
					entry_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: tb/tb_sorted_priority_queue_top.sv
// Self-checking testbench for sorted_priority_queue_top: drives request transactions and
// checks every result against a behavioral model of the sorted store kept here.
// Depends on spq_pkg and the sorted_priority_queue_top RTL.
`default_nettype none

module tb_sorted_priority_queue_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;

	typedef struct {
		spq_pkg::status_t          sts;
		logic [15:0]               elem;
		logic [15:0]               prio;
		logic                      hit;
		logic [spq_pkg::CNT_W-1:0] count;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [15:0] element;
	logic [15:0] priority_req;
	logic [15:0] target_priority;
	logic        done;
	logic [1:0]  status;
	logic [15:0] out_element;
	logic [15:0] out_priority;
	logic        found;
	logic [4:0]  size;

	sorted_priority_queue_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.element         (element),
		.priority_req    (priority_req),
		.target_priority (target_priority),
		.done            (done),
		.status          (status),
		.out_element     (out_element),
		.out_priority    (out_priority),
		.found           (found),
		.size            (size)
	);

	// Model of the sorted store
	logic [spq_pkg::KEY_WIDTH-1:0] q_elem [spq_pkg::DEPTH];
	logic [spq_pkg::PRIO_W-1:0]    q_prio [spq_pkg::DEPTH];
	int                            q_count;
	int                            q_iter;

	reply_t      replies_due[$];
	int          errors;
	int          burst_left;
	logic [15:0] key_pool [8];
	logic [15:0] prio_pool [8];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void drop_entry(int idx);
		for (int i = idx; i + 1 < q_count; i++) begin
			q_elem[i] = q_elem[i + 1];
			q_prio[i] = q_prio[i + 1];
		end
		q_count--;
	endfunction

	// Goes behind every entry of equal or higher priority
	function automatic void place_entry(logic [15:0] key, logic [15:0] prio);
		int pos;
		pos = q_count;
		for (int i = 0; i < q_count; i++) begin
			if (prio > q_prio[i]) begin
				pos = i;
				break;
			end
		end
		for (int i = q_count; i > pos; i--) begin
			q_elem[i] = q_elem[i - 1];
			q_prio[i] = q_prio[i - 1];
		end
		q_elem[pos] = key;
		q_prio[pos] = prio;
		q_count++;
	endfunction

	function automatic reply_t predict_reply(spq_pkg::req_t req, logic [15:0] key,
			logic [15:0] prio, logic [15:0] nprio);
		reply_t rep;
		int     idx;
		rep = '{sts: spq_pkg::STS_OK, elem: '0, prio: '0, hit: 1'b0, count: '0};
		idx = -1;
		case (req)
			spq_pkg::REQ_INSERT: begin
				if (q_count >= spq_pkg::DEPTH) begin
					rep.sts = spq_pkg::STS_FULL;
				end else begin
					place_entry(key, prio);
					q_iter = spq_pkg::DEPTH;
				end
			end
			spq_pkg::REQ_POP: begin
				if (q_count == 0) begin
					rep.sts = spq_pkg::STS_EMPTY;
				end else begin
					rep.elem = q_elem[0];
					rep.prio = q_prio[0];
					drop_entry(0);
					q_iter = spq_pkg::DEPTH;
				end
			end
			spq_pkg::REQ_REMOVE: begin
				for (int i = 0; i < q_count; i++) begin
					if (q_elem[i] == key) begin
						idx = i;
						break;
					end
				end
				if (idx >= 0) begin
					drop_entry(idx);
					q_iter = spq_pkg::DEPTH;
				end else begin
					rep.sts = spq_pkg::STS_NOTFOUND;
				end
			end
			spq_pkg::REQ_CHANGE: begin
				for (int i = 0; i < q_count; i++) begin
					if (q_elem[i] == key && q_prio[i] == prio) begin
						idx = i;
						break;
					end
				end
				if (idx >= 0) begin
					drop_entry(idx);
					place_entry(key, nprio);
					q_iter = spq_pkg::DEPTH;
				end else begin
					rep.sts = spq_pkg::STS_NOTFOUND;
				end
			end
			spq_pkg::REQ_CONTAINS: begin
				for (int i = 0; i < q_count; i++) begin
					if (q_elem[i] == key) rep.hit = 1'b1;
				end
			end
			spq_pkg::REQ_FIRST: begin
				if (q_count == 0) begin
					rep.sts = spq_pkg::STS_EMPTY;
					q_iter = spq_pkg::DEPTH;
				end else begin
					q_iter = 0;
					rep.elem = q_elem[0];
					rep.prio = q_prio[0];
				end
			end
			spq_pkg::REQ_NEXT: begin
				if (q_iter >= q_count || q_iter + 1 >= q_count) begin
					rep.sts = spq_pkg::STS_EMPTY;
					q_iter = spq_pkg::DEPTH;
				end else begin
					q_iter++;
					rep.elem = q_elem[q_iter];
					rep.prio = q_prio[q_iter];
				end
			end
			default: begin
				q_count = 0;
				q_iter = spq_pkg::DEPTH;
			end
		endcase
		rep.count = spq_pkg::CNT_W'(q_count);
		return rep;
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_key();
		if ($urandom_range(0, 3) == 0) return rnd16();
		return key_pool[$urandom_range(0, 7)];
	endfunction

	// Pool values make priority ties common
	function automatic logic [15:0] pick_prio();
		if ($urandom_range(0, 1) == 0) return rnd16();
		return prio_pool[$urandom_range(0, 7)];
	endfunction

	function automatic spq_pkg::req_t pick_op();
		int w;
		w = $urandom_range(0, 99);
		if (w < 28) return spq_pkg::REQ_INSERT;
		if (w < 38) return spq_pkg::REQ_POP;
		if (w < 50) return spq_pkg::REQ_REMOVE;
		if (w < 64) return spq_pkg::REQ_CHANGE;
		if (w < 74) return spq_pkg::REQ_CONTAINS;
		if (w < 82) return spq_pkg::REQ_FIRST;
		if (w < 97) return spq_pkg::REQ_NEXT;
		return spq_pkg::REQ_CLEAR;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// One request transaction; the sender works in bursts with random gaps
	task automatic send_req(spq_pkg::req_t r, logic [15:0] e, logic [15:0] p,
			logic [15:0] np);
		int gap;
		start           <= 1'b1;
		req_type        <= r;
		element         <= e;
		priority_req    <= p;
		target_priority <= np;
		@(posedge clk);
		while (busy) @(posedge clk);
		replies_due.push_back(predict_reply(r, e, p, np));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 12);
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results();
		start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_req(spq_pkg::REQ_POP, rnd16(), rnd16(), rnd16());
		send_req(spq_pkg::REQ_FIRST, rnd16(), rnd16(), rnd16());
		send_req(spq_pkg::REQ_NEXT, rnd16(), rnd16(), rnd16());
		send_req(spq_pkg::REQ_INSERT, 16'hFFFF, 16'hFFFF, rnd16());
		send_req(spq_pkg::REQ_INSERT, 16'h0000, 16'h0000, rnd16());
		send_req(spq_pkg::REQ_INSERT, 16'h1234, 16'h8000, rnd16());
		send_req(spq_pkg::REQ_INSERT, 16'h1234, 16'h0001, rnd16());
		// equal priority: lands behind the older 16'h1234 entry
		send_req(spq_pkg::REQ_INSERT, 16'hABCD, 16'h8000, rnd16());
		send_req(spq_pkg::REQ_FIRST, rnd16(), rnd16(), rnd16());
		send_req(spq_pkg::REQ_NEXT, rnd16(), rnd16(), rnd16());
		// contains must not move the iterator
		send_req(spq_pkg::REQ_CONTAINS, 16'h1234, rnd16(), rnd16());
		send_req(spq_pkg::REQ_NEXT, rnd16(), rnd16(), rnd16());
		send_req(spq_pkg::REQ_INSERT, 16'h5A5A, 16'h7FFF, rnd16());
		send_req(spq_pkg::REQ_NEXT, rnd16(), rnd16(), rnd16());
		send_req(spq_pkg::REQ_REMOVE, 16'h1234, rnd16(), rnd16());
		send_req(spq_pkg::REQ_REMOVE, 16'h5555, rnd16(), rnd16());
		send_req(spq_pkg::REQ_CHANGE, 16'h1234, 16'h8000, 16'hFFFF);
		send_req(spq_pkg::REQ_CHANGE, 16'h1234, 16'h0001, 16'h8000);
		send_req(spq_pkg::REQ_CONTAINS, 16'h5555, rnd16(), rnd16());
		send_req(spq_pkg::REQ_FIRST, rnd16(), rnd16(), rnd16());
		send_req(spq_pkg::REQ_POP, rnd16(), rnd16(), rnd16());
		send_req(spq_pkg::REQ_CLEAR, rnd16(), rnd16(), rnd16());
		send_req(spq_pkg::REQ_NEXT, rnd16(), rnd16(), rnd16());
		wait_results();
	endtask

	// Fill past full, then pop past empty
	task automatic test_fill_and_drain();
		repeat (4) begin
			send_req(spq_pkg::REQ_CLEAR, rnd16(), rnd16(), rnd16());
			for (int k = 0; k < spq_pkg::DEPTH + 2; k++)
				send_req(spq_pkg::REQ_INSERT, pick_key(), pick_prio(), rnd16());
			send_req(spq_pkg::REQ_CONTAINS, pick_key(), rnd16(), rnd16());
			for (int k = 0; k < spq_pkg::DEPTH + 2; k++)
				send_req(spq_pkg::REQ_POP, rnd16(), rnd16(), rnd16());
		end
		wait_results();
	endtask

	// first, then next to one past the end, with contains and the odd removal mixed in
	task automatic test_iterator_walks();
		int steps;
		repeat (14) begin
			if ($urandom_range(0, 2) == 0)
				send_req(spq_pkg::REQ_CLEAR, rnd16(), rnd16(), rnd16());
			repeat ($urandom_range(0, 6))
				send_req(spq_pkg::REQ_INSERT, pick_key(), pick_prio(), rnd16());
			send_req(spq_pkg::REQ_FIRST, rnd16(), rnd16(), rnd16());
			steps = q_count + 1;
			for (int k = 0; k < steps; k++) begin
				if ($urandom_range(0, 3) == 0)
					send_req(spq_pkg::REQ_CONTAINS, pick_key(), rnd16(), rnd16());
				if ($urandom_range(0, 19) == 0)
					send_req(spq_pkg::REQ_REMOVE, pick_key(), rnd16(), rnd16());
				send_req(spq_pkg::REQ_NEXT, rnd16(), rnd16(), rnd16());
			end
		end
		wait_results();
	endtask

	task automatic test_random_mix(int n);
		spq_pkg::req_t r;
		logic [15:0]   e;
		logic [15:0]   p;
		logic [15:0]   np;
		int            idx;
		for (int k = 0; k < n; k++) begin
			r  = pick_op();
			e  = pick_key();
			p  = pick_prio();
			np = pick_prio();
			if (q_count > 0) begin
				idx = $urandom_range(0, q_count - 1);
				if (r == spq_pkg::REQ_CHANGE && $urandom_range(0, 3) != 0) begin
					e = q_elem[idx];
					p = q_prio[idx];
				end else if ((r == spq_pkg::REQ_REMOVE || r == spq_pkg::REQ_CONTAINS)
						&& $urandom_range(0, 1)) begin
					e = q_elem[idx];
				end
			end
			send_req(r, e, p, np);
			if (k % 400 == 399) wait_results();
		end
		wait_results();
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done === 1'b1) begin
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual status %0d element %h",
					$time, status, out_element);
			end else begin
				want = replies_due.pop_front();
				check_field("status", 16'(want.sts), 16'(status));
				check_field("out_element", want.elem, out_element);
				check_field("out_priority", want.prio, out_priority);
				check_field("found", 16'(want.hit), 16'(found));
				check_field("size", 16'(want.count), 16'(size));
			end
		end
	end

	// Ends the run if no transaction moves on either side for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((start && !busy) || done === 1'b1) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_sorted_priority_queue_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		start           = 1'b0;
		req_type        = spq_pkg::REQ_INSERT;
		element         = '0;
		priority_req    = '0;
		target_priority = '0;
		errors          = 0;
		burst_left      = 0;
		q_count         = 0;
		q_iter          = spq_pkg::DEPTH;
		foreach (key_pool[i]) key_pool[i] = rnd16();
		foreach (prio_pool[i]) prio_pool[i] = rnd16();
		key_pool[0]  = 16'h0000;
		key_pool[1]  = 16'hFFFF;
		prio_pool[0] = 16'h0000;
		prio_pool[1] = 16'hFFFF;
		prio_pool[2] = 16'h8000;
		prio_pool[3] = 16'h7FFF;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_iterator_walks();
		test_random_mix(1300);

		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_sorted_priority_queue_top: done, clean");
		else
			$display("tb_sorted_priority_queue_top: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_top.sv
tb/tb_sorted_priority_queue_top.sv
